### design/mfp_pkg.sv
package mfp_pkg;

    localparam logic [7:0]  STX_V1          = 8'hFE;
    localparam logic [7:0]  STX_V2          = 8'hFD;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam int          SIGNATURE_BYTES = 13;
    localparam int          SIG_CNT_W       = 4;

    localparam logic [1:0]  VER_V1 = 2'd1;
    localparam logic [1:0]  VER_V2 = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_HEADER  = 1'b1;

    localparam logic [23:0] ID_A_RST    = 24'd0;
    localparam logic [7:0]  EXTRA_A_RST = 8'd50;
    localparam logic [23:0] ID_B_RST    = 24'd30;
    localparam logic [7:0]  EXTRA_B_RST = 8'd39;
    localparam logic [23:0] ID_C_RST    = 24'd33;
    localparam logic [7:0]  EXTRA_C_RST = 8'd104;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LEN     = 4'd1,
        PH_IFLAGS  = 4'd2,
        PH_CFLAGS  = 4'd3,
        PH_SEQ     = 4'd4,
        PH_SYS     = 4'd5,
        PH_COMP    = 4'd6,
        PH_MID1    = 4'd7,
        PH_MID2    = 4'd8,
        PH_MID3    = 4'd9,
        PH_PAYLOAD = 4'd10,
        PH_CRCLO   = 4'd11,
        PH_CRCHI   = 4'd12,
        PH_SIG     = 4'd13
    } t_phase;

    typedef enum logic [2:0] {
        CFG_ID_A    = 3'd0,
        CFG_EXTRA_A = 3'd1,
        CFG_ID_B    = 3'd2,
        CFG_EXTRA_B = 3'd3,
        CFG_ID_C    = 3'd4,
        CFG_EXTRA_C = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [1:0]  version;
        logic [7:0]  incompat_bits;
        logic [7:0]  compat_bits;
        logic [7:0]  sequence_res;
        logic [7:0]  system_id;
        logic [7:0]  component_id;
        logic [23:0] message_id;
        logic [7:0]  payload_length;
        logic [1:0]  status;
    } t_result;

    // One byte step of the X.25 / MCRF4XX checksum.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  t;
        logic [15:0] tw;
        t  = b ^ crc[7:0];
        t  = t ^ {t[3:0], 4'b0000};
        tw = {8'h00, t};
        return {8'h00, crc[15:8]} ^ (tw << 8) ^ (tw << 3) ^ (tw >> 4);
    endfunction

endpackage

### design/mavlink_frame_parser.sv
// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ------------------------------------
// in        sink       i_in_valid / o_in_ready     i_in_byte
// out       source     o_out_valid / i_out_ready   o_kind ... o_status (one result)
// cfg       sink       i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// Each accepted byte is fully handled in the cycle it is accepted: the phase logic,
// one CRC step (at the CRC high byte that step takes the CRC extra instead of the
// byte) and the id match feed the result register directly, so one beat per cycle is
// sustained unless the input is held off. A result appears on the out channel in the
// cycle after its byte. Reset is synchronous and active low. The input is held off
// only while a result waits in the result register and the out channel is not ready.
module mavlink_frame_parser
    import mfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic [1:0]  o_version,
    output logic [7:0]  o_incompat_bits,
    output logic [7:0]  o_compat_bits,
    output logic [7:0]  o_sequence_res,
    output logic [7:0]  o_system_id,
    output logic [7:0]  o_component_id,
    output logic [23:0] o_message_id,
    output logic [7:0]  o_payload_length,
    output logic [1:0]  o_status,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // Known message table, written through the configuration port.
    logic [23:0] r_id_a, r_id_b, r_id_c;
    logic [7:0]  r_extra_a, r_extra_b, r_extra_c;

    // Frame state.
    t_phase                r_phase,     n_phase;
    logic [15:0]           r_crc,       n_crc;
    logic [15:0]           r_rx_crc,    n_rx_crc;
    logic [7:0]            r_frame_len, n_frame_len;
    logic [7:0]            r_pay_cnt,   n_pay_cnt;
    logic [SIG_CNT_W-1:0]  r_sig_cnt,   n_sig_cnt;
    logic [1:0]            r_version,   n_version;
    logic [7:0]            r_incompat,  n_incompat;
    logic [7:0]            r_compat,    n_compat;
    logic [7:0]            r_seq,       n_seq;
    logic [7:0]            r_sysid,     n_sysid;
    logic [7:0]            r_compid,    n_compid;
    logic [23:0]           r_msgid,     n_msgid;
    logic                  r_signed,    n_signed;
    t_status               r_status,    n_status;

    // Result register.
    logic     r_out_valid;
    t_result  r_out;
    t_result  res;
    logic     res_vld;

    logic        in_acc;
    logic        id_hit;
    logic [7:0]  extra_sel;
    logic [15:0] crc_byte;
    logic [15:0] crc_final;
    logic [15:0] rx_full;
    logic [7:0]  pay_next;
    logic [SIG_CNT_W-1:0] sig_next;
    t_result     hdr;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // Priority match of the assembled id against the table: a before b before c.
    always_comb begin
        id_hit    = 1'b1;
        extra_sel = r_extra_c;
        if (r_msgid == r_id_a) begin
            extra_sel = r_extra_a;
        end else if (r_msgid == r_id_b) begin
            extra_sel = r_extra_b;
        end else if (r_msgid != r_id_c) begin
            id_hit = 1'b0;
        end
    end

    assign crc_byte  = crc_step(r_crc, i_in_byte);
    assign crc_final = crc_step(r_crc, extra_sel);
    assign rx_full   = {i_in_byte, r_rx_crc[7:0]};
    assign pay_next  = r_pay_cnt + 8'd1;
    assign sig_next  = r_sig_cnt + SIG_CNT_W'(1);

    // Header as it would leave with the current frame registers.
    always_comb begin
        hdr                = '0;
        hdr.kind           = KIND_HEADER;
        hdr.version        = r_version;
        hdr.incompat_bits  = r_incompat;
        hdr.compat_bits    = r_compat;
        hdr.sequence_res   = r_seq;
        hdr.system_id      = r_sysid;
        hdr.component_id   = r_compid;
        hdr.message_id     = r_msgid;
        hdr.payload_length = r_frame_len;
        hdr.status         = r_status;
    end

    // Next state and result for the byte on the input.
    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_rx_crc    = r_rx_crc;
        n_frame_len = r_frame_len;
        n_pay_cnt   = r_pay_cnt;
        n_sig_cnt   = r_sig_cnt;
        n_version   = r_version;
        n_incompat  = r_incompat;
        n_compat    = r_compat;
        n_seq       = r_seq;
        n_sysid     = r_sysid;
        n_compid    = r_compid;
        n_msgid     = r_msgid;
        n_signed    = r_signed;
        n_status    = r_status;
        res         = '0;
        res_vld     = 1'b0;

        if (in_acc) begin
            case (r_phase)
                PH_LEN: begin
                    n_frame_len = i_in_byte;
                    n_crc       = crc_byte;
                    n_phase     = (r_version == VER_V2) ? PH_IFLAGS : PH_SEQ;
                end
                PH_IFLAGS: begin
                    n_incompat = i_in_byte;
                    n_signed   = i_in_byte[0];
                    n_crc      = crc_byte;
                    n_phase    = PH_CFLAGS;
                end
                PH_CFLAGS: begin
                    n_compat = i_in_byte;
                    n_crc    = crc_byte;
                    n_phase  = PH_SEQ;
                end
                PH_SEQ: begin
                    n_seq   = i_in_byte;
                    n_crc   = crc_byte;
                    n_phase = PH_SYS;
                end
                PH_SYS: begin
                    n_sysid = i_in_byte;
                    n_crc   = crc_byte;
                    n_phase = PH_COMP;
                end
                PH_COMP: begin
                    n_compid = i_in_byte;
                    n_crc    = crc_byte;
                    n_phase  = PH_MID1;
                end
                PH_MID1: begin
                    n_crc   = crc_byte;
                    n_msgid = {16'h0000, i_in_byte};
                    if (r_version == VER_V2) begin
                        n_phase = PH_MID2;
                    end else begin
                        n_phase = (r_frame_len != 8'd0) ? PH_PAYLOAD : PH_CRCLO;
                    end
                end
                PH_MID2: begin
                    n_crc   = crc_byte;
                    n_msgid = {r_msgid[23:16], i_in_byte, r_msgid[7:0]};
                    n_phase = PH_MID3;
                end
                PH_MID3: begin
                    n_crc   = crc_byte;
                    n_msgid = {i_in_byte, r_msgid[15:0]};
                    n_phase = (r_frame_len != 8'd0) ? PH_PAYLOAD : PH_CRCLO;
                end
                PH_PAYLOAD: begin
                    n_crc          = crc_byte;
                    res.kind       = KIND_PAYLOAD;
                    res.data_byte  = i_in_byte;
                    res.byte_index = r_pay_cnt;
                    res_vld        = 1'b1;
                    n_pay_cnt      = pay_next;
                    if (pay_next >= r_frame_len) begin
                        n_phase = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    n_rx_crc = {8'h00, i_in_byte};
                    n_phase  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    n_rx_crc = rx_full;
                    if (id_hit) begin
                        n_crc    = crc_final;
                        n_status = (crc_final == rx_full) ? ST_OK : ST_CRC_ERR;
                    end else begin
                        n_status = ST_UNKNOWN;
                    end
                    if (r_signed) begin
                        n_sig_cnt = '0;
                        n_phase   = PH_SIG;
                    end else begin
                        n_phase    = PH_IDLE;
                        res        = hdr;
                        res.status = n_status;
                        res_vld    = 1'b1;
                    end
                end
                PH_SIG: begin
                    n_sig_cnt = sig_next;
                    if (32'(sig_next) >= SIGNATURE_BYTES) begin
                        n_phase = PH_IDLE;
                        res     = hdr;
                        res_vld = 1'b1;
                    end
                end
                default: begin
                    // Idle: hunt for a start byte; anything else is dropped.
                    if (i_in_byte == STX_V1 || i_in_byte == STX_V2) begin
                        n_version  = (i_in_byte == STX_V1) ? VER_V1 : VER_V2;
                        n_crc      = CRC_INIT;
                        n_pay_cnt  = '0;
                        n_sig_cnt  = '0;
                        n_incompat = '0;
                        n_compat   = '0;
                        n_msgid    = '0;
                        n_signed   = 1'b0;
                        n_phase    = PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_crc       <= CRC_INIT;
            r_rx_crc    <= '0;
            r_frame_len <= '0;
            r_pay_cnt   <= '0;
            r_sig_cnt   <= '0;
            r_version   <= '0;
            r_incompat  <= '0;
            r_compat    <= '0;
            r_seq       <= '0;
            r_sysid     <= '0;
            r_compid    <= '0;
            r_msgid     <= '0;
            r_signed    <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_phase     <= n_phase;
            r_crc       <= n_crc;
            r_rx_crc    <= n_rx_crc;
            r_frame_len <= n_frame_len;
            r_pay_cnt   <= n_pay_cnt;
            r_sig_cnt   <= n_sig_cnt;
            r_version   <= n_version;
            r_incompat  <= n_incompat;
            r_compat    <= n_compat;
            r_seq       <= n_seq;
            r_sysid     <= n_sysid;
            r_compid    <= n_compid;
            r_msgid     <= n_msgid;
            r_signed    <= n_signed;
            r_status    <= n_status;
        end
    end

    // Configuration writes; out-of-range indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_a    <= ID_A_RST;
            r_extra_a <= EXTRA_A_RST;
            r_id_b    <= ID_B_RST;
            r_extra_b <= EXTRA_B_RST;
            r_id_c    <= ID_C_RST;
            r_extra_c <= EXTRA_C_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ID_A:    r_id_a    <= i_cfg_data;
                CFG_EXTRA_A: r_extra_a <= i_cfg_data[7:0];
                CFG_ID_B:    r_id_b    <= i_cfg_data;
                CFG_EXTRA_B: r_extra_b <= i_cfg_data[7:0];
                CFG_ID_C:    r_id_c    <= i_cfg_data;
                CFG_EXTRA_C: r_extra_c <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Result register: loaded by a byte that yields a result, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_vld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data_byte      = r_out.data_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_version        = r_out.version;
    assign o_incompat_bits  = r_out.incompat_bits;
    assign o_compat_bits    = r_out.compat_bits;
    assign o_sequence_res   = r_out.sequence_res;
    assign o_system_id      = r_out.system_id;
    assign o_component_id   = r_out.component_id;
    assign o_message_id     = r_out.message_id;
    assign o_payload_length = r_out.payload_length;
    assign o_status         = r_out.status;

`ifndef SYNTHESIS
    // The input is only held off by a result that is waiting to be taken.
    a_ready_only_blocked_by_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    // A waiting payload beat always lies inside the declared payload.
    a_payload_index_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_PAYLOAD) |-> (o_byte_index < r_frame_len))
        else $error("payload index beyond frame length");

    // The signature counter never passes the signature length.
    a_sig_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIG) |-> (32'(r_sig_cnt) < SIGNATURE_BYTES))
        else $error("signature counter overran");

    // A beat taken while idle either starts a frame or is dropped.
    a_idle_no_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_IDLE) |=> (r_phase == PH_IDLE || r_phase == PH_LEN))
        else $error("idle beat led to an unexpected phase");
`endif

endmodule

### bench/tb_top.sv
// Scoreboard for the frame parser: it follows the byte stream beat by beat, keeps the
// expected payload and header beats in order, and matches each result against them.
class frame_scoreboard;
    logic [23:0] known_id [3];
    logic [7:0]  extra_tab [3];

    mfp_pkg::t_phase  phase;
    mfp_pkg::t_status verdict;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [7:0]  frame_len;
    logic [7:0]  pay_cnt;
    logic [3:0]  sig_cnt;
    logic [1:0]  ver;
    logic [7:0]  iflags;
    logic [7:0]  cflags;
    logic [7:0]  seq_no;
    logic [7:0]  sysid;
    logic [7:0]  compid;
    logic [23:0] msgid;
    logic        sig_frame;

    mfp_pkg::t_result expected_beats [$];
    int failures;

    function new();
        known_id[0]  = mfp_pkg::ID_A_RST;
        extra_tab[0] = mfp_pkg::EXTRA_A_RST;
        known_id[1]  = mfp_pkg::ID_B_RST;
        extra_tab[1] = mfp_pkg::EXTRA_B_RST;
        known_id[2]  = mfp_pkg::ID_C_RST;
        extra_tab[2] = mfp_pkg::EXTRA_C_RST;
        phase        = mfp_pkg::PH_IDLE;
        verdict      = mfp_pkg::ST_OK;
        crc_acc      = mfp_pkg::CRC_INIT;
        crc_rx       = '0;
        frame_len    = '0;
        pay_cnt      = '0;
        sig_cnt      = '0;
        ver          = '0;
        iflags       = '0;
        cflags       = '0;
        seq_no       = '0;
        sysid        = '0;
        compid       = '0;
        msgid        = '0;
        sig_frame    = 1'b0;
        failures     = 0;
    endfunction

    // X.25 (MCRF4XX) checksum, one byte at a time, reflected form.
    function logic [15:0] x25_next(input logic [15:0] c, input logic [7:0] b);
        logic [7:0]  mix;
        logic [15:0] wide;
        mix  = b ^ c[7:0];
        mix  = mix ^ (mix << 4);
        wide = {8'h00, mix};
        return (c >> 8) ^ {mix, 8'h00} ^ (wide << 3) ^ (wide >> 4);
    endfunction

    // The first table entry that matches wins.
    function bit lookup_extra(input logic [23:0] id, output logic [7:0] ex);
        ex = '0;
        for (int k = 0; k < 3; k++) begin
            if (known_id[k] == id) begin
                ex = extra_tab[k];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [23:0] v);
        case (idx)
            mfp_pkg::CFG_ID_A:    known_id[0]  = v;
            mfp_pkg::CFG_EXTRA_A: extra_tab[0] = v[7:0];
            mfp_pkg::CFG_ID_B:    known_id[1]  = v;
            mfp_pkg::CFG_EXTRA_B: extra_tab[1] = v[7:0];
            mfp_pkg::CFG_ID_C:    known_id[2]  = v;
            mfp_pkg::CFG_EXTRA_C: extra_tab[2] = v[7:0];
            default: ;
        endcase
    endfunction

    function mfp_pkg::t_result header_beat();
        mfp_pkg::t_result r;
        r                = '0;
        r.kind           = mfp_pkg::KIND_HEADER;
        r.version        = ver;
        r.incompat_bits  = iflags;
        r.compat_bits    = cflags;
        r.sequence_res   = seq_no;
        r.system_id      = sysid;
        r.component_id   = compid;
        r.message_id     = msgid;
        r.payload_length = frame_len;
        r.status         = verdict;
        return r;
    endfunction

    function void absorb_byte(input logic [7:0] b);
        mfp_pkg::t_result r;
        logic [7:0] ex;
        r = '0;
        case (phase)
            mfp_pkg::PH_LEN: begin
                frame_len = b;
                crc_acc   = x25_next(crc_acc, b);
                if (ver == mfp_pkg::VER_V2) phase = mfp_pkg::PH_IFLAGS;
                else phase = mfp_pkg::PH_SEQ;
            end
            mfp_pkg::PH_IFLAGS: begin
                iflags    = b;
                sig_frame = b[0];
                crc_acc   = x25_next(crc_acc, b);
                phase     = mfp_pkg::PH_CFLAGS;
            end
            mfp_pkg::PH_CFLAGS: begin
                cflags  = b;
                crc_acc = x25_next(crc_acc, b);
                phase   = mfp_pkg::PH_SEQ;
            end
            mfp_pkg::PH_SEQ: begin
                seq_no  = b;
                crc_acc = x25_next(crc_acc, b);
                phase   = mfp_pkg::PH_SYS;
            end
            mfp_pkg::PH_SYS: begin
                sysid   = b;
                crc_acc = x25_next(crc_acc, b);
                phase   = mfp_pkg::PH_COMP;
            end
            mfp_pkg::PH_COMP: begin
                compid  = b;
                crc_acc = x25_next(crc_acc, b);
                phase   = mfp_pkg::PH_MID1;
            end
            mfp_pkg::PH_MID1: begin
                msgid   = {16'h0000, b};
                crc_acc = x25_next(crc_acc, b);
                if (ver == mfp_pkg::VER_V2) phase = mfp_pkg::PH_MID2;
                else if (frame_len != 0) phase = mfp_pkg::PH_PAYLOAD;
                else phase = mfp_pkg::PH_CRCLO;
            end
            mfp_pkg::PH_MID2: begin
                msgid[15:8] = b;
                crc_acc     = x25_next(crc_acc, b);
                phase       = mfp_pkg::PH_MID3;
            end
            mfp_pkg::PH_MID3: begin
                msgid[23:16] = b;
                crc_acc      = x25_next(crc_acc, b);
                if (frame_len != 0) phase = mfp_pkg::PH_PAYLOAD;
                else phase = mfp_pkg::PH_CRCLO;
            end
            mfp_pkg::PH_PAYLOAD: begin
                crc_acc      = x25_next(crc_acc, b);
                r.kind       = mfp_pkg::KIND_PAYLOAD;
                r.data_byte  = b;
                r.byte_index = pay_cnt;
                expected_beats.push_back(r);
                pay_cnt = pay_cnt + 8'd1;
                if (pay_cnt >= frame_len) phase = mfp_pkg::PH_CRCLO;
            end
            mfp_pkg::PH_CRCLO: begin
                crc_rx = {8'h00, b};
                phase  = mfp_pkg::PH_CRCHI;
            end
            mfp_pkg::PH_CRCHI: begin
                crc_rx[15:8] = b;
                // Unknown ids skip the checksum compare altogether.
                if (!lookup_extra(msgid, ex)) begin
                    verdict = mfp_pkg::ST_UNKNOWN;
                end else begin
                    crc_acc = x25_next(crc_acc, ex);
                    if (crc_acc == crc_rx) verdict = mfp_pkg::ST_OK;
                    else verdict = mfp_pkg::ST_CRC_ERR;
                end
                if (sig_frame) begin
                    sig_cnt = '0;
                    phase   = mfp_pkg::PH_SIG;
                end else begin
                    phase = mfp_pkg::PH_IDLE;
                    expected_beats.push_back(header_beat());
                end
            end
            mfp_pkg::PH_SIG: begin
                sig_cnt = sig_cnt + 4'd1;
                if (32'(sig_cnt) >= mfp_pkg::SIGNATURE_BYTES) begin
                    phase = mfp_pkg::PH_IDLE;
                    expected_beats.push_back(header_beat());
                end
            end
            default: begin
                if (b == mfp_pkg::STX_V1 || b == mfp_pkg::STX_V2) begin
                    if (b == mfp_pkg::STX_V1) ver = mfp_pkg::VER_V1;
                    else ver = mfp_pkg::VER_V2;
                    crc_acc   = mfp_pkg::CRC_INIT;
                    pay_cnt   = '0;
                    sig_cnt   = '0;
                    iflags    = '0;
                    cflags    = '0;
                    msgid     = '0;
                    sig_frame = 1'b0;
                    phase     = mfp_pkg::PH_LEN;
                end
            end
        endcase
    endfunction

    function string show(input mfp_pkg::t_result r);
        return $sformatf({"kind=%0d data=%02h idx=%0d ver=%0d if=%02h cf=%02h seq=%02h",
                          " sys=%02h comp=%02h id=%06h len=%0d st=%0d"},
                         r.kind, r.data_byte, r.byte_index, r.version, r.incompat_bits,
                         r.compat_bits, r.sequence_res, r.system_id, r.component_id,
                         r.message_id, r.payload_length, r.status);
    endfunction

    function void note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void match_beat(input mfp_pkg::t_result got);
        mfp_pkg::t_result want;
        if (expected_beats.size() == 0) begin
            note_failure({"beat with nothing expected: ", show(got)});
            return;
        end
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.byte_index !== want.byte_index || got.version !== want.version ||
            got.incompat_bits !== want.incompat_bits ||
            got.compat_bits !== want.compat_bits ||
            got.sequence_res !== want.sequence_res || got.system_id !== want.system_id ||
            got.component_id !== want.component_id ||
            got.message_id !== want.message_id ||
            got.payload_length !== want.payload_length || got.status !== want.status) begin
            note_failure({"expected ", show(want), " got ", show(got)});
        end
    endfunction
endclass

module tb_top
    import mfp_pkg::*;
();

    // Register indexes past the table; the block must ignore writes to them.
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [23:0] cfg_data  = 24'h000000;

    logic        in_ready;
    logic        out_valid;
    logic        res_kind;
    logic [7:0]  res_data;
    logic [7:0]  res_index;
    logic [1:0]  res_version;
    logic [7:0]  res_iflags;
    logic [7:0]  res_cflags;
    logic [7:0]  res_seq;
    logic [7:0]  res_sysid;
    logic [7:0]  res_compid;
    logic [23:0] res_msgid;
    logic [7:0]  res_len;
    logic [1:0]  res_status;

    frame_scoreboard board;

    // Idle limits for each side, changed from phase to phase so that some stretches run
    // back to back and others have gaps landing anywhere inside a frame.
    int send_gap_max = 18;
    int recv_gap_max = 18;
    // A long output stall requested by the stimulus; the receiver counts it out itself.
    int hold_off     = 0;
    int beats_sent   = 0;

    mavlink_frame_parser dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_in_byte        (in_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_kind           (res_kind),
        .o_data_byte      (res_data),
        .o_byte_index     (res_index),
        .o_version        (res_version),
        .o_incompat_bits  (res_iflags),
        .o_compat_bits    (res_cflags),
        .o_sequence_res   (res_seq),
        .o_system_id      (res_sysid),
        .o_component_id   (res_compid),
        .o_message_id     (res_msgid),
        .o_payload_length (res_len),
        .o_status         (res_status),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one byte after a random gap and returns at the edge where the beat is
    // taken. Valid stays high across back-to-back beats, so it is only lowered when a
    // gap is drawn; the scoreboard sees the byte at the same edge as the block does.
    task automatic offer_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        board.absorb_byte(b);
        beats_sent++;
    endtask

    // Output side: an optional long hold-off, then a random stall per beat, then ready
    // stays high until a result beat is taken and checked.
    task automatic accept_results();
        int w;
        t_result r;
        forever begin
            if (hold_off > 0) begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, recv_gap_max);
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            r.kind           = res_kind;
            r.data_byte      = res_data;
            r.byte_index     = res_index;
            r.version        = res_version;
            r.incompat_bits  = res_iflags;
            r.compat_bits    = res_cflags;
            r.sequence_res   = res_seq;
            r.system_id      = res_sysid;
            r.component_id   = res_compid;
            r.message_id     = res_msgid;
            r.payload_length = res_len;
            r.status         = res_status;
            board.match_beat(r);
        end
    endtask

    // One register write per edge; the caller lowers the write enable after a batch.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        board.write_reg(idx, v);
    endtask

    // Loads the whole id/extra table. Callers may pass extras with junk in the upper data
    // bits to show that they are masked, and the two spare indexes get random writes as well.
    task automatic program_table(input logic [23:0] ida, input logic [23:0] exa,
                                 input logic [23:0] idb, input logic [23:0] exb,
                                 input logic [23:0] idc, input logic [23:0] exc);
        write_reg(CFG_ID_A, ida);
        write_reg(CFG_EXTRA_A, exa);
        write_reg(CFG_ID_B, idb);
        write_reg(CFG_EXTRA_B, exb);
        write_reg(CFG_ID_C, idc);
        write_reg(CFG_EXTRA_C, exc);
        write_reg(CFG_SPARE_6, 24'($urandom));
        write_reg(CFG_SPARE_7, 24'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Drop valid and wait for every expected beat, then wait on in case a byte that
    // produces nothing is still being absorbed.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.expected_beats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_id();
        if ($urandom_range(0, 1) != 0) return 24'($urandom_range(0, 255));
        return 24'($urandom);
    endfunction

    // Mostly ids from the current table so that checksums get verified; the rest are
    // arbitrary and usually unknown.
    function automatic logic [23:0] pick_id();
        if ($urandom_range(0, 9) < 7) return board.known_id[$urandom_range(0, 2)];
        return rand_id();
    endfunction

    // Short payloads dominate to keep the run quick; a few long ones reach the top.
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 8'($urandom_range(0, 12));
        if (r < 97) return 8'($urandom_range(13, 80));
        return 8'($urandom_range(200, 255));
    endfunction

    // Builds a complete frame with a valid or deliberately broken checksum and sends
    // it, or only its first cut bytes when cut is not negative. A fill value that is
    // not negative replaces every payload byte.
    task automatic send_frame(input logic [1:0] ver, input logic [7:0] len,
                              input logic [23:0] mid, input logic [7:0] iflags,
                              input bit bad_crc, input int cut, input int fill);
        logic [7:0]  fb [$];
        logic [15:0] c;
        logic [7:0]  ex;
        logic [23:0] id;
        int n;
        id = (ver == VER_V1) ? {16'h0000, mid[7:0]} : mid;
        fb.push_back((ver == VER_V1) ? STX_V1 : STX_V2);
        fb.push_back(len);
        if (ver == VER_V2) begin
            fb.push_back(iflags);
            fb.push_back(8'($urandom_range(0, 255)));
        end
        repeat (3) fb.push_back(8'($urandom_range(0, 255)));
        fb.push_back(id[7:0]);
        if (ver == VER_V2) begin
            fb.push_back(id[15:8]);
            fb.push_back(id[23:16]);
        end
        repeat (len) fb.push_back(8'((fill >= 0) ? fill : $urandom_range(0, 255)));
        c = CRC_INIT;
        for (int i = 1; i < fb.size(); i++) c = board.x25_next(c, fb[i]);
        if (board.lookup_extra(id, ex)) c = board.x25_next(c, ex);
        if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        if (ver == VER_V2 && iflags[0]) begin
            repeat (SIGNATURE_BYTES) fb.push_back(8'($urandom_range(0, 255)));
        end
        n = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
        for (int i = 0; i < n; i++) offer_byte(fb[i]);
    endtask

    // Mostly well-formed frames with random content; a little line noise between
    // frames and the odd truncated frame, after which the parser has to find its way
    // back through whatever follows.
    task automatic random_traffic(input int beats);
        int goal;
        int pick;
        logic [1:0] ver;
        logic [7:0] iflags;
        logic [7:0] junk;
        goal = beats_sent + beats;
        while (beats_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                repeat ($urandom_range(1, 4)) begin
                    do junk = 8'($urandom_range(0, 255));
                    while (junk == STX_V1 || junk == STX_V2);
                    offer_byte(junk);
                end
            end else begin
                ver       = ($urandom_range(0, 1) != 0) ? VER_V2 : VER_V1;
                iflags    = 8'($urandom_range(0, 255));
                iflags[0] = ($urandom_range(0, 3) == 0);
                send_frame(ver, pick_length(), pick_id(), iflags,
                           $urandom_range(0, 4) == 0,
                           (pick < 10) ? $urandom_range(1, 8) : -1, -1);
            end
        end
    endtask

    initial begin
        @(posedge clk);
        accept_results();
    end

    initial begin
        logic [23:0] shared_id;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening on the reset table: idle noise is dropped, a zero-length v1
        // frame for the first known id, then a v2 frame with an unknown id, every
        // incompat bit set except the signed one, and a start byte inside the payload.
        offer_byte(8'h00);
        offer_byte(8'hFF);
        send_frame(VER_V1, 8'd0, ID_A_RST, 8'h00, 1'b0, -1, -1);
        send_frame(VER_V2, 8'd1, 24'hFFFFFF, 8'hFE, 1'b0, -1, int'(STX_V2));
        random_traffic(150);
        settle();

        // Random table, no idling on either side, and one long output stall so that the
        // result register fills and the input has to wait.
        program_table(rand_id(), 24'($urandom), rand_id(), 24'($urandom), rand_id(),
                      24'($urandom));
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_off     = 400;
        random_traffic(230);
        settle();

        // All ids zero: the first entry must win, and the extra of zero is used.
        program_table(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
        send_gap_max = 18;
        recv_gap_max = 0;
        random_traffic(230);
        settle();

        // Everything at its maximum, including a full-length signed v2 frame.
        program_table(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      24'hFFFFFF);
        send_gap_max = 0;
        recv_gap_max = 18;
        send_frame(VER_V2, 8'd255, 24'hFFFFFF, 8'hFF, 1'b0, -1, -1);
        random_traffic(230);
        settle();

        // Second and third entries share an id, so the second one decides.
        shared_id = 24'($urandom_range(0, 255));
        program_table(shared_id ^ 24'h000001, 24'($urandom), shared_id, 24'($urandom),
                      shared_id, 24'($urandom));
        send_gap_max = 18;
        recv_gap_max = 18;
        random_traffic(230);
        settle();

        program_table(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      rand_id(), 24'($urandom));
        send_gap_max = 9;
        recv_gap_max = 18;
        random_traffic(230);
        settle();

        if (board.failures == 0 && board.expected_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule

### filelist.f
design/mfp_pkg.sv
design/mavlink_frame_parser.sv
bench/tb_top.sv
